// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk outside reset.
`define MSQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("check failed");

// Check that a condition never holds.
`define MSQ_NEVER(lbl, cond) \
    `MSQ_ASSERT(lbl, !(cond))

`endif

// ===== rtl/msq_pkg.sv =====
`default_nettype none
package msq_pkg;

    localparam int CW    = 12;  // col / row
    localparam int DW    = 32;  // samples, coordinates
    localparam int SW    = 16;  // step registers
    localparam int NUMW  = 33;  // sample differences
    localparam int PRODW = 28;  // index times step
    localparam int BW    = 34;  // vertex coordinate before saturation
    localparam int MAGW  = 49;  // |num| * step
    localparam int UW    = 51;  // dividend
    localparam int RW    = 35;  // divisor and partial remainder
    localparam int QW    = 17;  // offset along an edge, 0..step
    localparam int PW    = 35;  // crossing coordinate before saturation
    localparam int LANES = 4;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_STEP_X   = 2'd2;
    localparam logic [1:0] REG_STEP_Y   = 2'd3;

    typedef enum logic [1:0] {
        EDGE_BOT   = 2'd0,  // a -> b
        EDGE_RIGHT = 2'd1,  // b -> d
        EDGE_TOP   = 2'd2,  // d -> c
        EDGE_LEFT  = 2'd3   // c -> a
    } edge_id_t;

    localparam logic [1:0] PAIR_CNT [16] = '{
        2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0
    };

    localparam edge_id_t PAIR_EDGE [16][4] = '{
        '{EDGE_BOT,   EDGE_BOT,   EDGE_BOT,   EDGE_BOT},
        '{EDGE_BOT,   EDGE_LEFT,  EDGE_BOT,   EDGE_BOT},
        '{EDGE_RIGHT, EDGE_BOT,   EDGE_BOT,   EDGE_BOT},
        '{EDGE_RIGHT, EDGE_LEFT,  EDGE_BOT,   EDGE_BOT},
        '{EDGE_TOP,   EDGE_RIGHT, EDGE_BOT,   EDGE_BOT},
        '{EDGE_BOT,   EDGE_LEFT,  EDGE_TOP,   EDGE_RIGHT},
        '{EDGE_TOP,   EDGE_BOT,   EDGE_BOT,   EDGE_BOT},
        '{EDGE_TOP,   EDGE_LEFT,  EDGE_BOT,   EDGE_BOT},
        '{EDGE_LEFT,  EDGE_TOP,   EDGE_BOT,   EDGE_BOT},
        '{EDGE_BOT,   EDGE_TOP,   EDGE_BOT,   EDGE_BOT},
        '{EDGE_RIGHT, EDGE_BOT,   EDGE_LEFT,  EDGE_TOP},
        '{EDGE_RIGHT, EDGE_TOP,   EDGE_BOT,   EDGE_BOT},
        '{EDGE_LEFT,  EDGE_RIGHT, EDGE_BOT,   EDGE_BOT},
        '{EDGE_BOT,   EDGE_RIGHT, EDGE_BOT,   EDGE_BOT},
        '{EDGE_LEFT,  EDGE_BOT,   EDGE_BOT,   EDGE_BOT},
        '{EDGE_BOT,   EDGE_BOT,   EDGE_BOT,   EDGE_BOT}
    };

    // Cell context that rides along with the division.
    typedef struct packed {
        logic signed [BW-1:0] x0;
        logic signed [BW-1:0] x1;
        logic signed [BW-1:0] y0;
        logic signed [BW-1:0] y1;
        logic [3:0]           cs;
        logic                 pos;
    } side_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [DW-1:0] r;
        if ((&v[PW-1:DW-1]) || !(|v[PW-1:DW-1])) begin
            r = v[DW-1:0];
        end else begin
            r = {v[PW-1], {(DW-1){~v[PW-1]}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/msq_front.sv =====
`default_nettype none
module msq_front
    import msq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic signed [DW-1:0] origin_x,
    input  wire logic signed [DW-1:0] origin_y,
    input  wire logic [SW-1:0]        step_x,
    input  wire logic [SW-1:0]        step_y,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CW-1:0]        col,
    input  wire logic [CW-1:0]        row,
    input  wire logic signed [DW-1:0] corner_a,
    input  wire logic signed [DW-1:0] corner_b,
    input  wire logic signed [DW-1:0] corner_c,
    input  wire logic signed [DW-1:0] corner_d,
    input  wire logic signed [DW-1:0] level,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [LANES-1:0][UW-1:0]  out_u,
    output logic [LANES-1:0][RW-1:0]  out_d,
    output side_t                     out_side
);

    logic en1, en2, en3;

    // stage 1: differences, case, index products
    logic                                v1_reg;
    logic signed [LANES-1:0][NUMW-1:0]   num1_reg, num1_next;
    logic signed [LANES-1:0][NUMW-1:0]   den1_reg, den1_next;
    logic [PRODW-1:0]                    colx1_reg, rowy1_reg;
    logic [3:0]                          cs1_reg, cs1_next;
    logic                                pos1_reg;

    // stage 2: magnitudes, products, vertex bases
    logic                                v2_reg;
    logic [LANES-1:0][MAGW-1:0]          mag2_reg, mag2_next;
    logic [LANES-1:0][NUMW-1:0]          dab2_reg, dab2_next;
    side_t                               side2_reg, side2_next;

    // stage 3: dividend and divisor
    logic                                v3_reg;
    logic [LANES-1:0][UW-1:0]            u3_reg, u3_next;
    logic [LANES-1:0][RW-1:0]            d3_reg, d3_next;
    side_t                               side3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        num1_next[EDGE_BOT]   = NUMW'(level)    - NUMW'(corner_a);
        den1_next[EDGE_BOT]   = NUMW'(corner_b) - NUMW'(corner_a);
        num1_next[EDGE_RIGHT] = NUMW'(level)    - NUMW'(corner_b);
        den1_next[EDGE_RIGHT] = NUMW'(corner_d) - NUMW'(corner_b);
        num1_next[EDGE_TOP]   = NUMW'(level)    - NUMW'(corner_d);
        den1_next[EDGE_TOP]   = NUMW'(corner_c) - NUMW'(corner_d);
        num1_next[EDGE_LEFT]  = NUMW'(level)    - NUMW'(corner_c);
        den1_next[EDGE_LEFT]  = NUMW'(corner_a) - NUMW'(corner_c);
        cs1_next = {corner_c >= level, corner_d >= level,
                    corner_b >= level, corner_a >= level};
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [NUMW-1:0] an;
            logic [SW-1:0]   st;
            an = num1_reg[i][NUMW-1] ? NUMW'(-num1_reg[i]) : NUMW'(num1_reg[i]);
            dab2_next[i] = den1_reg[i][NUMW-1] ? NUMW'(-den1_reg[i])
                                               : NUMW'(den1_reg[i]);
            st = (i[0] == 1'b0) ? step_x : step_y;
            mag2_next[i] = MAGW'(an) * MAGW'(st);
        end
        side2_next.x0  = BW'(origin_x) + BW'(colx1_reg);
        side2_next.x1  = BW'(origin_x) + BW'(colx1_reg) + BW'(step_x);
        side2_next.y0  = BW'(origin_y) + BW'(rowy1_reg);
        side2_next.y1  = BW'(origin_y) + BW'(rowy1_reg) + BW'(step_y);
        side2_next.cs  = cs1_reg;
        side2_next.pos = pos1_reg;
    end

    // Edges walked in the negative direction round half-ties the other way.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            u3_next[i] = UW'({mag2_reg[i], 1'b0}) + UW'(dab2_reg[i])
                       - UW'(i >= EDGE_TOP);
            d3_next[i] = {1'b0, dab2_reg[i], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            num1_reg  <= num1_next;
            den1_reg  <= den1_next;
            colx1_reg <= PRODW'(col) * PRODW'(step_x);
            rowy1_reg <= PRODW'(row) * PRODW'(step_y);
            cs1_reg   <= cs1_next;
            pos1_reg  <= !level[DW-1];
        end
        if (en2) begin
            mag2_reg  <= mag2_next;
            dab2_reg  <= dab2_next;
            side2_reg <= side2_next;
        end
        if (en3) begin
            u3_reg    <= u3_next;
            d3_reg    <= d3_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_u     = u3_reg;
    assign out_d     = d3_reg;
    assign out_side  = side3_reg;

endmodule
`default_nettype wire

// ===== rtl/msq_div.sv =====
`default_nettype none
module msq_div
    import msq_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [LANES-1:0][UW-1:0]  in_u,
    input  wire logic [LANES-1:0][RW-1:0]  in_d,
    input  wire side_t                     in_side,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [LANES-1:0][QW-1:0]       out_q,
    output side_t                          out_side
);

    localparam int STEPS = 2;
    localparam int NSTG  = (QW + STEPS - 1) / STEPS;

    logic                        v_reg    [NSTG];
    logic [LANES-1:0][RW-1:0]    rem_reg  [NSTG];
    logic [LANES-1:0][QW-1:0]    ulo_reg  [NSTG];
    logic [LANES-1:0][QW-1:0]    q_reg    [NSTG];
    logic [LANES-1:0][RW-1:0]    d_reg    [NSTG];
    side_t                       side_reg [NSTG];
    logic [NSTG:0]               en;

    assign en[NSTG] = out_ready;
    assign in_ready = en[0];

    genvar g;
    for (g = 0; g < NSTG; g++) begin : g_stage
        logic                     v_src;
        logic [LANES-1:0][RW-1:0] rem_src, rem_next, d_src;
        logic [LANES-1:0][QW-1:0] ulo_src, ulo_next, q_src, q_next;
        side_t                    side_src;

        if (g == 0) begin : g_first
            always_comb begin
                v_src    = in_valid;
                d_src    = in_d;
                side_src = in_side;
                for (int i = 0; i < LANES; i++) begin
                    rem_src[i] = {1'b0, in_u[i][UW-1:QW]};
                    ulo_src[i] = in_u[i][QW-1:0];
                    q_src[i]   = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                v_src    = v_reg[g-1];
                rem_src  = rem_reg[g-1];
                ulo_src  = ulo_reg[g-1];
                q_src    = q_reg[g-1];
                d_src    = d_reg[g-1];
                side_src = side_reg[g-1];
            end
        end

        // Restoring division, one quotient bit per step.
        always_comb begin
            logic [RW-1:0] r;
            logic [RW-1:0] t;
            logic [QW-1:0] u;
            logic [QW-1:0] q;
            for (int i = 0; i < LANES; i++) begin
                r = rem_src[i];
                u = ulo_src[i];
                q = q_src[i];
                for (int k = 0; k < STEPS; k++) begin
                    if (g * STEPS + k < QW) begin
                        t = {r[RW-2:0], u[QW-1]};
                        u = {u[QW-2:0], 1'b0};
                        if (t >= d_src[i]) begin
                            r = t - d_src[i];
                            q = {q[QW-2:0], 1'b1};
                        end else begin
                            r = t;
                            q = {q[QW-2:0], 1'b0};
                        end
                    end
                end
                rem_next[i] = r;
                ulo_next[i] = u;
                q_next[i]   = q;
            end
        end

        assign en[g] = !v_reg[g] || en[g+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en[g]) begin
                v_reg[g] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[g]) begin
                rem_reg[g]  <= rem_next;
                ulo_reg[g]  <= ulo_next;
                q_reg[g]    <= q_next;
                d_reg[g]    <= d_src;
                side_reg[g] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_q     = q_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule
`default_nettype wire

// ===== rtl/msq_emit.sv =====
`default_nettype none
module msq_emit
    import msq_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [LANES-1:0][QW-1:0]  in_q,
    input  wire side_t                     in_side,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [DW-1:0]           m_start_x,
    output logic signed [DW-1:0]           m_start_y,
    output logic signed [DW-1:0]           m_end_x,
    output logic signed [DW-1:0]           m_end_y,
    output logic                           m_positive,
    output logic                           m_last
);

    typedef struct packed {
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] sy;
        logic signed [DW-1:0] ex;
        logic signed [DW-1:0] ey;
        logic                 pos;
    } seg_t;

    // point stage
    logic                              vp_reg;
    logic signed [LANES-1:0][DW-1:0]   px_reg, px_next, py_reg, py_next;
    logic [3:0]                        cs_reg;
    logic                              pos_reg;
    logic                              enp;

    // two-slot hold for the segments of one cell
    logic                              h0_reg, h1_reg;
    seg_t                              s0_reg, s1_reg;
    logic                              hold_ready;
    logic                              fire;
    seg_t                              seg  [2];
    logic                              keep [2];

    assign fire       = h0_reg && m_ready;
    assign hold_ready = !h0_reg || (!h1_reg && m_ready);
    assign enp        = !vp_reg || hold_ready;
    assign in_ready   = enp;

    always_comb begin
        px_next[EDGE_BOT]   = sat32(PW'(in_side.x0) + PW'(in_q[EDGE_BOT]));
        py_next[EDGE_BOT]   = sat32(PW'(in_side.y0));
        px_next[EDGE_RIGHT] = sat32(PW'(in_side.x1));
        py_next[EDGE_RIGHT] = sat32(PW'(in_side.y0) + PW'(in_q[EDGE_RIGHT]));
        px_next[EDGE_TOP]   = sat32(PW'(in_side.x1) - PW'(in_q[EDGE_TOP]));
        py_next[EDGE_TOP]   = sat32(PW'(in_side.y1));
        px_next[EDGE_LEFT]  = sat32(PW'(in_side.x0));
        py_next[EDGE_LEFT]  = sat32(PW'(in_side.y1) - PW'(in_q[EDGE_LEFT]));
    end

    // Pick the edge pairs of the case; drop pairs that collapse to a point.
    always_comb begin
        edge_id_t ea, eb;
        for (int k = 0; k < 2; k++) begin
            ea = PAIR_EDGE[cs_reg][2*k];
            eb = PAIR_EDGE[cs_reg][2*k+1];
            seg[k].sx  = px_reg[ea];
            seg[k].sy  = py_reg[ea];
            seg[k].ex  = px_reg[eb];
            seg[k].ey  = py_reg[eb];
            seg[k].pos = pos_reg;
            keep[k]    = (2'(k) < PAIR_CNT[cs_reg]) &&
                         !(px_reg[ea] == px_reg[eb] && py_reg[ea] == py_reg[eb]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            h0_reg <= 1'b0;
            h1_reg <= 1'b0;
        end else begin
            if (enp) vp_reg <= in_valid;
            if (vp_reg && hold_ready) begin
                h0_reg <= keep[0] || keep[1];
                h1_reg <= keep[0] && keep[1];
            end else if (fire) begin
                h0_reg <= h1_reg;
                h1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (enp) begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            cs_reg  <= in_side.cs;
            pos_reg <= in_side.pos;
        end
        if (vp_reg && hold_ready) begin
            s0_reg <= keep[0] ? seg[0] : seg[1];
            s1_reg <= seg[1];
        end else if (fire) begin
            s0_reg <= s1_reg;
        end
    end

    assign m_valid    = h0_reg;
    assign m_start_x  = s0_reg.sx;
    assign m_start_y  = s0_reg.sy;
    assign m_end_x    = s0_reg.ex;
    assign m_end_y    = s0_reg.ey;
    assign m_positive = s0_reg.pos;
    assign m_last     = !h1_reg;

endmodule
`default_nettype wire

// ===== rtl/marching_squares_cell_segments.sv =====
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    col, row, corner_a..d, level
// m_        out        m_valid/m_ready    start_x/y, end_x/y, positive, last
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// A request passes 14 registers on its way to the output, the first loaded at
// the accepting edge: 3 front stages, 9 divider stages (two quotient bits each
// but the last, which takes one; all four lanes in parallel), one point stage and
// the output hold register.
// One request enters per cycle unless m_ready stalls; a cell with two segments
// fills both hold slots and stalls the pipeline behind it until the first is taken.
// Reset clears only valid bits and configuration, with no clearing pass.
// A stall backs up stage by stage; empty stages keep taking requests.
module marching_squares_cell_segments
    import msq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [DW-1:0]        cfg_data,
    // cell requests
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CW-1:0]        s_col,
    input  wire logic [CW-1:0]        s_row,
    input  wire logic signed [DW-1:0] s_corner_a,
    input  wire logic signed [DW-1:0] s_corner_b,
    input  wire logic signed [DW-1:0] s_corner_c,
    input  wire logic signed [DW-1:0] s_corner_d,
    input  wire logic signed [DW-1:0] s_level,
    // segments
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [DW-1:0]      m_start_x,
    output logic signed [DW-1:0]      m_start_y,
    output logic signed [DW-1:0]      m_end_x,
    output logic signed [DW-1:0]      m_end_y,
    output logic                      m_positive,
    output logic                      m_last
);

    localparam logic [SW-1:0] STEP_RESET = SW'(20);

    logic signed [DW-1:0] origin_x_reg, origin_y_reg;
    logic [SW-1:0]        step_x_reg, step_y_reg;

    // Hold configuration; the user must write it only while the pipeline is empty (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            step_x_reg   <= STEP_RESET;
            step_y_reg   <= STEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                REG_STEP_X:   step_x_reg   <= cfg_data[SW-1:0];
                REG_STEP_Y:   step_y_reg   <= cfg_data[SW-1:0];
                default:      ;
            endcase
        end
    end

    // front -> divider
    logic                     fd_valid, fd_ready;
    logic [LANES-1:0][UW-1:0] fd_u;
    logic [LANES-1:0][RW-1:0] fd_d;
    side_t                    fd_side;

    // divider -> emit
    logic                     de_valid, de_ready;
    logic [LANES-1:0][QW-1:0] de_q;
    side_t                    de_side;

    // Form differences, case, dividends and divisors for the bottom, right, top and left edges.
    msq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .step_x    (step_x_reg),
        .step_y    (step_y_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .col       (s_col),
        .row       (s_row),
        .corner_a  (s_corner_a),
        .corner_b  (s_corner_b),
        .corner_c  (s_corner_c),
        .corner_d  (s_corner_d),
        .level     (s_level),
        .out_valid (fd_valid),
        .out_ready (fd_ready),
        .out_u     (fd_u),
        .out_d     (fd_d),
        .out_side  (fd_side)
    );

    // Advance the rounded edge offsets two quotient bits per stage (one in the last).
    msq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fd_valid),
        .in_ready  (fd_ready),
        .in_u      (fd_u),
        .in_d      (fd_d),
        .in_side   (fd_side),
        .out_valid (de_valid),
        .out_ready (de_ready),
        .out_q     (de_q),
        .out_side  (de_side)
    );

    // Place crossings, drop collapsed segments, emit one segment per cycle while m_ready is high.
    msq_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (de_valid),
        .in_ready   (de_ready),
        .in_q       (de_q),
        .in_side    (de_side),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_start_x  (m_start_x),
        .m_start_y  (m_start_y),
        .m_end_x    (m_end_x),
        .m_end_y    (m_end_y),
        .m_positive (m_positive),
        .m_last     (m_last)
    );

endmodule
`default_nettype wire

// ===== rtl/msq_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module msq_checker
    import msq_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic signed [DW-1:0] m_start_x,
    input wire logic signed [DW-1:0] m_start_y,
    input wire logic signed [DW-1:0] m_end_x,
    input wire logic signed [DW-1:0] m_end_y,
    input wire logic                 m_last
);

    // A stalled segment holds its payload.
    `MSQ_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_start_x) && $stable(m_start_y) && $stable(m_end_x) && $stable(m_end_y) && $stable(m_last))

    // Collapsed segments are dropped before the port.
    `MSQ_NEVER(a_no_point, m_valid && m_start_x == m_end_x && m_start_y == m_end_y)

    // Back-pressure at the input only comes from a waiting segment.
    `MSQ_ASSERT(a_stall_src, !s_ready |-> m_valid)

endmodule

bind marching_squares_cell_segments msq_checker u_msq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_start_x (m_start_x),
    .m_start_y (m_start_y),
    .m_end_x   (m_end_x),
    .m_end_y   (m_end_y),
    .m_last    (m_last)
);
`default_nettype wire
